// ===== sv/wor_pkg.sv =====
package wor_pkg;

  localparam int unsigned DataW         = 32;
  localparam int unsigned PixW          = 8;
  localparam int unsigned NumCols       = 4;
  localparam int unsigned ScaleFracBits = 24;
  localparam int unsigned MidDepth      = 2;
  localparam int unsigned OutDepth      = 4;

  localparam logic [1:0] RowFirst = 2'd0;
  localparam logic [1:0] RowBotLd = 2'd1;
  localparam logic [1:0] RowSub   = 2'd2;
  localparam logic [1:0] RowLast  = 2'd3;

  // Finished tile handed from the accumulator front to the requant back end.
  typedef struct packed {
    logic [NumCols-1:0][DataW-1:0] top;
    logic [NumCols-1:0][DataW-1:0] bot;
    logic [DataW-1:0]              bias;
    logic [DataW-1:0]              scale;
  } tile_word_t;

  typedef struct packed {
    logic [NumCols-1:0][PixW-1:0] pix;  // r0c0, r0c1, r1c0, r1c1
  } pix_word_t;

endpackage

// ===== sv/wor_fifo.sv =====
module wor_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [Width-1:0]           wdata_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [Width-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth+1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == DepthCnt);
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== sv/wor_front.sv =====
module wor_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  output logic                    full_o,
  input  logic [wor_pkg::DataW-1:0] col0_i,
  input  logic [wor_pkg::DataW-1:0] col1_i,
  input  logic [wor_pkg::DataW-1:0] col2_i,
  input  logic [wor_pkg::DataW-1:0] col3_i,
  input  logic [wor_pkg::DataW-1:0] bias_i,
  input  logic [wor_pkg::DataW-1:0] scale_i,
  // tile queue write side
  output logic                    tile_push_o,
  output wor_pkg::tile_word_t     tile_o,
  input  logic                    tile_full_i
);

  logic [1:0] row_q, row_d;
  logic [wor_pkg::NumCols-1:0][wor_pkg::DataW-1:0] top_q, top_d, bot_q, bot_d, x;
  logic accept;

  assign x      = {col3_i, col2_i, col1_i, col0_i};
  // only the closing row needs room in the tile queue
  assign full_o = (row_q == wor_pkg::RowLast) && tile_full_i;
  assign accept = push_i && !full_o;

  always_comb begin
    top_d = top_q;
    bot_d = bot_q;
    row_d = row_q;
    if (accept) begin
      row_d = row_q + 2'd1;
      for (int i = 0; i < wor_pkg::NumCols; i++) begin
        unique case (row_q)
          wor_pkg::RowFirst: top_d[i] = x[i];
          wor_pkg::RowBotLd: begin
            top_d[i] = top_q[i] + x[i];
            bot_d[i] = x[i];
          end
          wor_pkg::RowSub: begin
            top_d[i] = top_q[i] + x[i];
            bot_d[i] = bot_q[i] - x[i];
          end
          wor_pkg::RowLast: bot_d[i] = bot_q[i] + x[i];
          default: ;
        endcase
      end
    end
  end

  assign tile_push_o = accept && (row_q == wor_pkg::RowLast);
  always_comb begin
    tile_o.top   = top_q;
    tile_o.bot   = bot_d;
    tile_o.bias  = bias_i;
    tile_o.scale = scale_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= wor_pkg::RowFirst;
      top_q <= '0;
      bot_q <= '0;
    end else begin
      row_q <= row_d;
      top_q <= top_d;
      bot_q <= bot_d;
    end
  end

endmodule

// ===== sv/wor_back.sv =====
module wor_back #(
  parameter int unsigned SCALE_FRAC_BITS = wor_pkg::ScaleFracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // tile queue read side
  input  logic                tile_empty_i,
  input  wor_pkg::tile_word_t tile_i,
  output logic                tile_pop_o,
  // result queue write side
  input  logic [$clog2(wor_pkg::OutDepth+1)-1:0] out_cnt_i,
  output logic                res_push_o,
  output wor_pkg::pix_word_t  res_o
);

  localparam int unsigned NC = wor_pkg::NumCols;
  localparam int unsigned DW = wor_pkg::DataW;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned CntW = $clog2(wor_pkg::OutDepth+1);
  localparam logic [PW-1:0] RemMask = (PW'(1) << SCALE_FRAC_BITS) - PW'(1);
  localparam logic [PW-1:0] Half    = PW'(1) << (SCALE_FRAC_BITS - 1);
  localparam logic [PW-1:0] PosMax  = PW'(127);
  localparam logic [PW-1:0] NegMax  = PW'(128);

  logic s1_v_q, s2_v_q, s3_v_q;
  logic [NC-1:0][DW-1:0] sum_q, sum_d;
  logic [DW-1:0]         scale_q;
  logic [NC-1:0][PW-1:0] prod_q, prod_d;
  logic [NC-1:0]         neg_q, neg_d;
  logic [NC-1:0][PW-1:0] qr_q, qr_d;
  logic [NC-1:0]         neg3_q;
  logic [CntW-1:0]       in_flight;

  // reserve a result slot for every word already in the pipe
  assign in_flight  = CntW'(s1_v_q) + CntW'(s2_v_q) + CntW'(s3_v_q);
  assign tile_pop_o = !tile_empty_i &&
                      ((out_cnt_i + in_flight) < CntW'(wor_pkg::OutDepth));

  // column transform plus bias, 32-bit wrap
  always_comb begin
    sum_d[0] = tile_i.top[0] + tile_i.top[1] + tile_i.top[2] + tile_i.bias;
    sum_d[1] = tile_i.top[1] - tile_i.top[2] + tile_i.top[3] + tile_i.bias;
    sum_d[2] = tile_i.bot[0] + tile_i.bot[1] + tile_i.bot[2] + tile_i.bias;
    sum_d[3] = tile_i.bot[1] - tile_i.bot[2] + tile_i.bot[3] + tile_i.bias;
  end

  // magnitude times scale; -(-2^31) wraps to 2^31, the correct magnitude
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      logic [DW-1:0] mag;
      neg_d[i]  = sum_q[i][DW-1];
      mag       = neg_d[i] ? (~sum_q[i] + 1'b1) : sum_q[i];
      prod_d[i] = PW'(mag) * PW'(scale_q);
    end
  end

  // round half to even on the magnitude
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      logic [PW-1:0] q, rem;
      logic          inc;
      q        = prod_q[i] >> SCALE_FRAC_BITS;
      rem      = prod_q[i] & RemMask;
      inc      = (rem > Half) || ((rem == Half) && q[0]);
      qr_d[i]  = q + PW'(inc);
    end
  end

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      if (neg3_q[i]) begin
        res_o.pix[i] = (qr_q[i] >= NegMax) ? 8'h80 : (8'd0 - qr_q[i][7:0]);
      end else begin
        res_o.pix[i] = (qr_q[i] > PosMax) ? 8'h7f : qr_q[i][7:0];
      end
    end
  end

  assign res_push_o = s3_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= tile_pop_o;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tile_pop_o) begin
      sum_q   <= sum_d;
      scale_q <= tile_i.scale;
    end
    if (s1_v_q) begin
      prod_q <= prod_d;
      neg_q  <= neg_d;
    end
    if (s2_v_q) begin
      qr_q   <= qr_d;
      neg3_q <= neg_q;
    end
  end

endmodule

// ===== sv/winograd_output_requantize.sv =====
// Channel   Direction  Handshake          Payload
// rows      in         push_i / full_o    col0_i..col3_i, chan_bias_i, chan_scale_i
// pixels    out        pop_i / empty_o    out_r0c0_o, out_r0c1_o, out_r1c0_o, out_r1c1_o
//
// One tile row is taken per cycle while full_o is low; every fourth row closes a tile and
// yields one word. A closed tile passes a 2-entry tile queue, then a 3-stage requant pipe
// (transform, 32x32 multiply, round), then a 4-entry result queue.
// full_o rises only on a closing row while the tile queue is full; rows 0..2 are never held.
// Reset clears the row count, accumulators and both queues.
module winograd_output_requantize #(
  parameter int unsigned SCALE_FRAC_BITS = wor_pkg::ScaleFracBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  output logic                                full_o,
  input  logic signed [wor_pkg::DataW-1:0]    col0_i,
  input  logic signed [wor_pkg::DataW-1:0]    col1_i,
  input  logic signed [wor_pkg::DataW-1:0]    col2_i,
  input  logic signed [wor_pkg::DataW-1:0]    col3_i,
  input  logic signed [wor_pkg::DataW-1:0]    chan_bias_i,
  input  logic        [wor_pkg::DataW-1:0]    chan_scale_i,
  output logic                                empty_o,
  input  logic                                pop_i,
  output logic signed [wor_pkg::PixW-1:0]     out_r0c0_o,
  output logic signed [wor_pkg::PixW-1:0]     out_r0c1_o,
  output logic signed [wor_pkg::PixW-1:0]     out_r1c0_o,
  output logic signed [wor_pkg::PixW-1:0]     out_r1c1_o
);

  localparam int unsigned TileW = $bits(wor_pkg::tile_word_t);
  localparam int unsigned PixWW = $bits(wor_pkg::pix_word_t);
  localparam int unsigned OutCntW = $clog2(wor_pkg::OutDepth+1);

  wor_pkg::tile_word_t tile_wr, tile_rd;
  wor_pkg::pix_word_t  res_wr, res_rd;
  logic tile_push, tile_full, tile_pop, tile_empty, res_push;
  logic [OutCntW-1:0] out_cnt;

  wor_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .col0_i      (col0_i),
    .col1_i      (col1_i),
    .col2_i      (col2_i),
    .col3_i      (col3_i),
    .bias_i      (chan_bias_i),
    .scale_i     (chan_scale_i),
    .tile_push_o (tile_push),
    .tile_o      (tile_wr),
    .tile_full_i (tile_full)
  );

  wor_fifo #(
    .Width (TileW),
    .Depth (wor_pkg::MidDepth)
  ) u_tile_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tile_push),
    .wdata_i (tile_wr),
    .full_o  (tile_full),
    .pop_i   (tile_pop),
    .rdata_o (tile_rd),
    .empty_o (tile_empty),
    .count_o ()
  );

  wor_back #(
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tile_empty_i (tile_empty),
    .tile_i       (tile_rd),
    .tile_pop_o   (tile_pop),
    .out_cnt_i    (out_cnt),
    .res_push_o   (res_push),
    .res_o        (res_wr)
  );

  wor_fifo #(
    .Width (PixWW),
    .Depth (wor_pkg::OutDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_wr),
    .full_o  (),
    .pop_i   (pop_i),
    .rdata_o (res_rd),
    .empty_o (empty_o),
    .count_o (out_cnt)
  );

  assign out_r0c0_o = res_rd.pix[0];
  assign out_r0c1_o = res_rd.pix[1];
  assign out_r1c0_o = res_rd.pix[2];
  assign out_r1c1_o = res_rd.pix[3];

endmodule

// ===== verif/wor_pixel_check.sv =====
module wor_pixel_check
  import wor_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  logic                     full_i,
  input  logic [DataW-1:0]         col0_i,
  input  logic [DataW-1:0]         col1_i,
  input  logic [DataW-1:0]         col2_i,
  input  logic [DataW-1:0]         col3_i,
  input  logic [DataW-1:0]         chan_bias_i,
  input  logic [DataW-1:0]         chan_scale_i,
  input  logic                     empty_i,
  input  logic                     pop_i,
  input  logic signed [PixW-1:0]   out_r0c0_i,
  input  logic signed [PixW-1:0]   out_r0c1_i,
  input  logic signed [PixW-1:0]   out_r1c0_i,
  input  logic signed [PixW-1:0]   out_r1c1_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  localparam int unsigned FracBits = ScaleFracBits;

  typedef struct packed {
    logic signed [PixW-1:0] r0c0;
    logic signed [PixW-1:0] r0c1;
    logic signed [PixW-1:0] r1c0;
    logic signed [PixW-1:0] r1c1;
  } pix_quad_t;

  logic [1:0]       row_idx;
  logic [DataW-1:0] top_acc [NumCols];
  logic [DataW-1:0] bot_acc [NumCols];
  pix_quad_t        expected_pix_q [$];
  int               n_bad  = 0;
  int               n_wait = 0;

  assign fail_count_o = n_bad;
  assign pending_o    = n_wait;

  // Scale by unsigned fixed point, round half to even on the magnitude, clamp to int8.
  function automatic logic [PixW-1:0] requant_pix(logic [DataW-1:0] v, logic [DataW-1:0] scale);
    logic             neg;
    logic [DataW-1:0] mag;
    logic [63:0]      prod;
    logic [63:0]      q;
    logic [63:0]      rem;
    logic [63:0]      half;
    logic [PixW-1:0]  pix;
    neg  = v[DataW-1];
    mag  = neg ? -v : v;  // most negative value maps onto itself as unsigned
    prod = 64'(mag) * 64'(scale);
    q    = prod >> FracBits;
    rem  = prod & ((64'd1 << FracBits) - 64'd1);
    half = 64'd1 << (FracBits - 1);
    if (rem > half || (rem == half && q[0])) begin
      q = q + 64'd1;
    end
    if (neg) begin
      if (q > 64'd128) begin
        q = 64'd128;
      end
      pix = q[PixW-1:0];
      return -pix;
    end
    if (q > 64'd127) begin
      q = 64'd127;
    end
    return q[PixW-1:0];
  endfunction

  function automatic void absorb_row(logic [DataW-1:0] c0, logic [DataW-1:0] c1,
                                     logic [DataW-1:0] c2, logic [DataW-1:0] c3,
                                     logic [DataW-1:0] bias, logic [DataW-1:0] scale);
    logic [DataW-1:0] x [NumCols];
    pix_quad_t        quad;
    x[0] = c0;
    x[1] = c1;
    x[2] = c2;
    x[3] = c3;
    for (int i = 0; i < NumCols; i++) begin
      case (row_idx)
        RowFirst: begin
          top_acc[i] = x[i];
        end
        RowBotLd: begin
          top_acc[i] = top_acc[i] + x[i];
          bot_acc[i] = x[i];
        end
        RowSub: begin
          top_acc[i] = top_acc[i] + x[i];
          bot_acc[i] = bot_acc[i] - x[i];
        end
        default: begin
          bot_acc[i] = bot_acc[i] + x[i];
        end
      endcase
    end
    if (row_idx == RowLast) begin
      quad.r0c0 = requant_pix(top_acc[0] + top_acc[1] + top_acc[2] + bias, scale);
      quad.r0c1 = requant_pix(top_acc[1] - top_acc[2] + top_acc[3] + bias, scale);
      quad.r1c0 = requant_pix(bot_acc[0] + bot_acc[1] + bot_acc[2] + bias, scale);
      quad.r1c1 = requant_pix(bot_acc[1] - bot_acc[2] + bot_acc[3] + bias, scale);
      expected_pix_q.push_back(quad);
    end
    row_idx = row_idx + 2'd1;
  endfunction

  function automatic void check_pix(string tag, logic signed [PixW-1:0] want,
                                    logic signed [PixW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, tag, want, got);
      n_bad++;
    end
  endfunction

  always @(posedge clk_i) begin : watch
    pix_quad_t want;
    if (!rst_ni) begin
      row_idx = RowFirst;
      for (int i = 0; i < NumCols; i++) begin
        top_acc[i] = '0;
        bot_acc[i] = '0;
      end
      expected_pix_q.delete();
    end else begin
      if (pop_i && !empty_i) begin
        if (expected_pix_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %0d %0d %0d %0d", $time,
                   out_r0c0_i, out_r0c1_i, out_r1c0_i, out_r1c1_i);
          n_bad++;
        end else begin
          want = expected_pix_q.pop_front();
          check_pix("r0c0", want.r0c0, out_r0c0_i);
          check_pix("r0c1", want.r0c1, out_r0c1_i);
          check_pix("r1c0", want.r1c0, out_r1c0_i);
          check_pix("r1c1", want.r1c1, out_r1c1_i);
        end
      end
      if (push_i && !full_i) begin
        absorb_row(col0_i, col1_i, col2_i, col3_i, chan_bias_i, chan_scale_i);
      end
    end
    n_wait = expected_pix_q.size();
  end

endmodule

// ===== verif/tb_winograd_output_requantize.sv =====
module tb_winograd_output_requantize;
  import wor_pkg::*;

  localparam int unsigned RandRows = 1100;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    push_i;
  logic                    full_o;
  logic signed [DataW-1:0] col0_i;
  logic signed [DataW-1:0] col1_i;
  logic signed [DataW-1:0] col2_i;
  logic signed [DataW-1:0] col3_i;
  logic signed [DataW-1:0] chan_bias_i;
  logic        [DataW-1:0] chan_scale_i;
  logic                    empty_o;
  logic                    pop_i;
  logic signed [PixW-1:0]  out_r0c0_o;
  logic signed [PixW-1:0]  out_r0c1_o;
  logic signed [PixW-1:0]  out_r1c0_o;
  logic signed [PixW-1:0]  out_r1c1_o;

  int fail_count;
  int pending;
  int burst_left;

  winograd_output_requantize dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_o       (full_o),
    .col0_i       (col0_i),
    .col1_i       (col1_i),
    .col2_i       (col2_i),
    .col3_i       (col3_i),
    .chan_bias_i  (chan_bias_i),
    .chan_scale_i (chan_scale_i),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .out_r0c0_o   (out_r0c0_o),
    .out_r0c1_o   (out_r0c1_o),
    .out_r1c0_o   (out_r1c0_o),
    .out_r1c1_o   (out_r1c1_o)
  );

  wor_pixel_check u_pixel_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_i       (full_o),
    .col0_i       (col0_i),
    .col1_i       (col1_i),
    .col2_i       (col2_i),
    .col3_i       (col3_i),
    .chan_bias_i  (chan_bias_i),
    .chan_scale_i (chan_scale_i),
    .empty_i      (empty_o),
    .pop_i        (pop_i),
    .out_r0c0_i   (out_r0c0_o),
    .out_r0c1_i   (out_r0c1_o),
    .out_r1c0_i   (out_r1c0_o),
    .out_r1c1_i   (out_r1c1_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

  // Gap in the row stream; col0_i and col1_i carry junk meanwhile.
  task automatic rest(input int n);
    @(negedge clk_i);
    push_i <= 1'b0;
    col0_i <= $urandom;
    col1_i <= $urandom;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic send_row(input logic [DataW-1:0] c0, input logic [DataW-1:0] c1,
                          input logic [DataW-1:0] c2, input logic [DataW-1:0] c3,
                          input logic [DataW-1:0] bias, input logic [DataW-1:0] scale);
    if (burst_left == 0) begin
      rest($urandom_range(1, 6));
      burst_left = $urandom_range(1, 40);
    end
    @(negedge clk_i);
    push_i       <= 1'b1;
    col0_i       <= c0;
    col1_i       <= c1;
    col2_i       <= c2;
    col3_i       <= c3;
    chan_bias_i  <= bias;
    chan_scale_i <= scale;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    burst_left--;
  endtask

  // Whole tile of one element value; handy for corner cases.
  task automatic send_flat_tile(input logic [DataW-1:0] e, input logic [DataW-1:0] bias,
                                input logic [DataW-1:0] scale);
    repeat (NumCols) send_row(e, e, e, e, bias, scale);
  endtask

  function automatic logic [DataW-1:0] pick_elem(input int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 2047) - 1024;
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      default: return $urandom_range(0, 1) ? $urandom : $urandom_range(0, 127) - 64;
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_scale();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0200_0000);
      2: return 32'd1 << $urandom_range(0, 31);
      3: return $urandom_range(0, 32'h0004_0000);
      default: begin
        case ($urandom_range(0, 2))
          0: return 32'h0000_0000;
          1: return 32'h0080_0000;  // one half: exposes ties
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  initial begin : stim
    int mode;
    int rows_sent;
    rst_ni       = 1'b0;
    push_i       = 1'b0;
    col0_i       = '0;
    col1_i       = '0;
    col2_i       = '0;
    col3_i       = '0;
    chan_bias_i  = '0;
    chan_scale_i = '0;
    burst_left   = 0;
    rows_sent    = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_flat_tile(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_flat_tile(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_flat_tile(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
    // half-way cases, both signs, then a most-negative bias at unit scale
    send_flat_tile(32'h0000_0001, -32'sd2, 32'h0080_0000);
    send_flat_tile(32'hFFFF_FFFF, 32'sd2, 32'h0080_0000);
    send_flat_tile(32'h0000_0000, 32'h8000_0000, 32'h0100_0000);

    while (rows_sent < RandRows) begin
      mode = $urandom_range(0, 3);
      for (int r = 0; r < 4; r++) begin
        if (r == 3) begin
          send_row(pick_elem(mode), pick_elem(mode), pick_elem(mode), pick_elem(mode),
                   mode == 0 ? $urandom : $urandom_range(0, 511) - 256, pick_scale());
        end else begin
          send_row(pick_elem(mode), pick_elem(mode), pick_elem(mode), pick_elem(mode),
                   $urandom, $urandom);
        end
        rows_sent++;
      end
    end

    @(negedge clk_i);
    push_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver: free-running, random, or mostly stalled, in segments.
  initial begin : drain
    int mode;
    int len;
    pop_i = 1'b0;
    wait (rst_ni);
    forever begin
      mode = $urandom_range(0, 2);
      len  = $urandom_range(10, 80);
      repeat (len) begin
        @(negedge clk_i);
        case (mode)
          0: pop_i <= 1'b1;
          1: pop_i <= 1'($urandom_range(0, 1));
          default: pop_i <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

endmodule

// ===== filelist.f =====
sv/wor_pkg.sv
sv/wor_fifo.sv
sv/wor_front.sv
sv/wor_back.sv
sv/winograd_output_requantize.sv
verif/wor_pixel_check.sv
verif/tb_winograd_output_requantize.sv
